>>> rtl/core/mqd_pkg.sv
`default_nettype none
package mqd_pkg;

  localparam int CMD_W = 1;
  localparam int QIDX_W = 2;
  localparam int SVC_W = 16;
  localparam int DELTA_W = 32;
  localparam int SERVED_W = 32;
  localparam int BUSY_W = 48;
  localparam int ACTQ_W = 3;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [1:0] REG_ACTIVE_QUEUES = 2'd0;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [QIDX_W-1:0]  queue_index;
    logic [SVC_W-1:0]   job_ticks;
    logic [DELTA_W-1:0] time_delta;
  } in_item_t;

  typedef struct packed {
    logic [QIDX_W-1:0] chosen_queue;
    logic [SVC_W-1:0]  min_remaining;
    logic              push_rejected;
  } out_item_t;

  // Control between the top level and the shared divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/mqd_ram.sv
`default_nettype none
module mqd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/mqd_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle: 48-bit dividend over 32-bit divisor.
module mqd_div
  import mqd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [BUSY_W-1:0]   dividend,
  input  wire logic [SERVED_W-1:0] divisor,
  output logic      [BUSY_W-1:0]   quotient,
  output div_ctl_t                 ctl
);

  localparam int CNT_W = $clog2(BUSY_W + 1);

  logic [CNT_W-1:0]    cnt;
  logic [SERVED_W:0]   rem;
  logic [SERVED_W-1:0] dsr;
  logic [SERVED_W:0]   trial;
  logic                running;
  logic                fin;

  assign trial = {rem[SERVED_W-1:0], quotient[BUSY_W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= CNT_W'(BUSY_W);
        rem <= '0;
        dsr <= divisor;
        quotient <= dividend;
      end else if (running) begin
        if (!trial[SERVED_W]) begin
          rem <= trial;
          quotient <= {quotient[BUSY_W-2:0], 1'b1};
        end else begin
          rem <= {rem[SERVED_W-1:0], quotient[BUSY_W-1]};
          quotient <= {quotient[BUSY_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy = running;
  assign ctl.done = fin;

endmodule
`default_nettype wire

>>> rtl/core/multi_queue_least_time_dispatcher.sv
`default_nettype none
// Join-shortest-queue dispatcher. The input is stalled while a transaction is
// in progress, and also while a result waits to be taken. A push goes straight
// to the choice; an advance first walks the active queues, retiring finished
// jobs and loading the next job of a queue into service from the store. A
// sequencer walks the queues one at a time through the single job-store read
// port, and one shared bit-serial divider computes each queue's average service
// time for the choice. No clearing pass is needed after reset.
module multi_queue_least_time_dispatcher
  import mqd_pkg::*;
#(
  parameter int NUM_QUEUES = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(NUM_QUEUES + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic [SERVED_W-1:0] SMAX = '1;
  localparam logic [BUSY_W-1:0] BMAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_ADV_CHK, S_ADV_RD, S_ADV_LOAD, S_SCAN, S_DIV_GO, S_DIV_WAIT,
    S_OUT
  } state_t;

  state_t state;
  logic [ACTQ_W-1:0] active_queues;
  logic [PW-1:0] head_pointer [NUM_QUEUES];
  logic [CW-1:0] entry_count [NUM_QUEUES];
  logic [SERVED_W-1:0] jobs_served [NUM_QUEUES];
  logic [BUSY_W-1:0] busy_time [NUM_QUEUES];
  logic [TIME_BITS-1:0] time_left [NUM_QUEUES];

  logic [QW-1:0] qi;
  logic [DELTA_W-1:0] ticks;
  logic [DELTA_W-1:0] delta;
  logic [QW-1:0] best;
  logic [CW-1:0] best_cnt;
  logic [BUSY_W-1:0] best_avg;
  logic [TIME_BITS-1:0] least;
  logic rejected;
  out_item_t result;

  logic [NW-1:0] nq;
  always_comb begin
    if (active_queues == '0) begin
      nq = NW'(1);
    end else if (32'(active_queues) > NUM_QUEUES) begin
      nq = NW'(NUM_QUEUES);
    end else begin
      nq = NW'(active_queues);
    end
  end
  logic last_q;
  assign last_q = (32'(qi) + 1 >= 32'(nq));

  // Job store as one RAM, address {queue, slot}.
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [TIME_BITS-1:0] ram_wdata, ram_rdata;
  mqd_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_QUEUES * QUEUE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [QW-1:0] pq;
  assign pq = QW'(in_data.queue_index);
  logic push_ok;
  assign push_ok = (32'(in_data.queue_index) < 32'(nq)) &&
                   (32'(entry_count[pq]) < QUEUE_DEPTH);
  logic [PW:0] slot_sum;
  assign slot_sum = (PW+1)'(head_pointer[pq]) + (PW+1)'(entry_count[pq]);
  logic [PW-1:0] slot;
  assign slot = (32'(slot_sum) >= QUEUE_DEPTH) ?
                PW'(32'(slot_sum) - QUEUE_DEPTH) : PW'(slot_sum);
  logic [TIME_BITS-1:0] st_sat;
  always_comb begin
    if (in_data.job_ticks == '0) begin
      st_sat = TIME_BITS'(1);
    end else if (32'(in_data.job_ticks) > 32'(TMAX)) begin
      st_sat = TMAX;
    end else begin
      st_sat = TIME_BITS'(in_data.job_ticks);
    end
  end
  logic in_take;
  assign in_take = in_valid && !in_stall;
  assign ram_we = in_take && (in_data.cmd == CMD_PUSH) && push_ok;
  assign ram_waddr = AW'(32'(pq) * QUEUE_DEPTH + 32'(slot));
  assign ram_wdata = st_sat;
  assign ram_raddr = AW'(32'(qi) * QUEUE_DEPTH + 32'(head_pointer[qi]));

  // Shared divider for average service time.
  logic div_start;
  logic [BUSY_W-1:0] div_q;
  div_ctl_t div_ctl;
  assign div_start = (state == S_DIV_GO);
  mqd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(busy_time[qi]),
    .divisor(jobs_served[qi]), .quotient(div_q), .ctl(div_ctl)
  );

  logic [BUSY_W-1:0] add_sum;
  logic [BUSY_W:0] add_raw;
  logic [BUSY_W-1:0] add_b;
  assign add_b = (32'(ticks) < 32'(time_left[qi]) || time_left[qi] == '0) ?
                 BUSY_W'(ticks) : BUSY_W'(time_left[qi]);
  assign add_raw = {1'b0, busy_time[qi]} + {1'b0, add_b};
  assign add_sum = add_raw[BUSY_W] ? BMAX : add_raw[BUSY_W-1:0];

  logic [PW-1:0] head_inc;
  assign head_inc = (32'(head_pointer[qi]) + 1 >= QUEUE_DEPTH) ? '0 :
                    PW'(32'(head_pointer[qi]) + 1);

  assign in_stall = (state != S_IDLE) || out_valid;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ACTIVE_QUEUES) ? 32'(active_queues) : 32'd0;
  assign out_data = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      active_queues <= ACTQ_W'(4);
      qi <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_pointer[i] <= '0;
        entry_count[i] <= '0;
        jobs_served[i] <= '0;
        busy_time[i] <= '0;
        time_left[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite && paddr == REG_ACTIVE_QUEUES) begin
        active_queues <= pwdata[ACTQ_W-1:0];
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            qi <= '0;
            ticks <= in_data.time_delta;
            delta <= in_data.time_delta;
            rejected <= (in_data.cmd == CMD_PUSH) && !push_ok;
            if (in_data.cmd == CMD_ADVANCE) begin
              state <= S_ADV_CHK;
            end else begin
              if (push_ok) begin
                entry_count[pq] <= entry_count[pq] + 1'b1;
              end
              state <= S_SCAN;
            end
          end
        end
        S_ADV_CHK: begin
          if (entry_count[qi] == '0) begin
            time_left[qi] <= '0;
            state <= last_q ? S_SCAN : S_ADV_CHK;
            if (last_q) qi <= '0; else qi <= qi + 1'b1;
            ticks <= delta;
          end else if (ticks < 32'(time_left[qi])) begin
            busy_time[qi] <= add_sum;
            time_left[qi] <= time_left[qi] - TIME_BITS'(ticks);
            state <= last_q ? S_SCAN : S_ADV_CHK;
            if (last_q) qi <= '0; else qi <= qi + 1'b1;
            ticks <= delta;
          end else begin
            if (time_left[qi] != '0) begin
              head_pointer[qi] <= head_inc;
              entry_count[qi] <= entry_count[qi] - 1'b1;
              if (jobs_served[qi] != SMAX) jobs_served[qi] <= jobs_served[qi] + 1'b1;
              busy_time[qi] <= add_sum;
              ticks <= ticks - 32'(time_left[qi]);
              time_left[qi] <= '0;
            end
            state <= S_ADV_RD;
          end
        end
        S_ADV_RD: begin
          if (entry_count[qi] == '0) begin
            state <= S_ADV_CHK;
          end else begin
            state <= S_ADV_LOAD;
          end
        end
        S_ADV_LOAD: begin
          time_left[qi] <= ram_rdata;
          state <= S_ADV_CHK;
        end
        S_SCAN: begin
          best <= '0;
          best_cnt <= entry_count[0];
          least <= '0;
          qi <= '0;
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_ctl.done) begin
            if (time_left[qi] != '0 && (least == '0 || time_left[qi] < least)) begin
              least <= time_left[qi];
            end
            if (qi == '0) begin
              best_avg <= (jobs_served[qi] == '0) ? '0 : div_q;
            end else if (entry_count[qi] < best_cnt ||
                         (entry_count[qi] == best_cnt &&
                          ((jobs_served[qi] == '0) ? '0 : div_q) < best_avg)) begin
              best <= qi;
              best_cnt <= entry_count[qi];
              best_avg <= (jobs_served[qi] == '0) ? '0 : div_q;
            end
            if (last_q) begin
              state <= S_OUT;
            end else begin
              qi <= qi + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_OUT: begin
          result.chosen_queue <= QIDX_W'(best);
          result.min_remaining <= SVC_W'(least);
          result.push_rejected <= rejected;
          out_valid <= 1'b1;
          qi <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result lost under stall");
  a_div_once: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_ctl.busy) else $error("divider restarted while busy");

endmodule
`default_nettype wire
